### src/bss_pkg.sv
// Shared types and codes for the bounded stack with search.
`default_nettype none

package bss_pkg;

    localparam int WORD_W = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SEARCH
    } state_t;

endpackage

`default_nettype wire

### src/bss_mem.sv
// Stack storage: one write port, one read port with registered read data.
`default_nettype none

module bss_mem
    import bss_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire word_t         wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output word_t              rdata
);

    word_t store_mem [DEPTH];
    word_t rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### src/bss_ctrl.sv
// Command sequencer: fill count, memory access and the top-down search walk.
`default_nettype none

module bss_ctrl
    import bss_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [CMD_W-1:0]  command,
    input  wire word_t             value,
    output logic                   done,
    output logic [STAT_W-1:0]      status,
    output word_t                  data,
    output logic [CW-1:0]          position,
    output logic [CW-1:0]          depth,
    output logic                   is_empty,
    // memory side
    output logic                   mem_we,
    output logic [AW-1:0]          mem_waddr,
    output word_t                  mem_wdata,
    output logic                   mem_re,
    output logic [AW-1:0]          mem_raddr,
    input  wire word_t             mem_rdata
);

    state_t             state_reg,  state_next;
    logic [CMD_W-1:0]   cmd_reg,    cmd_next;
    word_t              val_reg,    val_next;
    logic [CW-1:0]      count_reg,  count_next;
    logic [CW-1:0]      idx_reg,    idx_next;
    logic               done_reg,   done_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    word_t              data_reg,   data_next;
    logic [CW-1:0]      pos_reg,    pos_next;

    logic [CW-1:0]      cnt_inc;
    logic [CW-1:0]      cnt_dec;
    logic [CW-1:0]      idx_dec;
    logic [CW-1:0]      idx_dec2;

    assign cnt_inc  = count_reg + CW'(1);
    assign cnt_dec  = count_reg - CW'(1);
    assign idx_dec  = idx_reg - CW'(1);
    assign idx_dec2 = idx_reg - CW'(2);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        pos_reg    <= pos_next;
    end

    // Next state and memory control
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        val_next    = val_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        done_next   = 1'b0;
        status_next = STAT_OK;
        data_next   = '0;
        pos_next    = '0;
        mem_we      = 1'b0;
        mem_waddr   = count_reg[AW-1:0];
        mem_wdata   = val_reg;
        mem_re      = 1'b0;
        mem_raddr   = cnt_dec[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = command;
                    val_next   = value;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                unique case (cmd_reg) inside
                    CMD_PUSH:
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                        if (count_reg == CW'(DEPTH))
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            count_next = cnt_inc;
                        end
                    end

                    CMD_POP, CMD_PEEK:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STAT_EMPTY;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            state_next = S_READ;
                            if (cmd_reg == CMD_POP)
                            begin
                                count_next = cnt_dec;
                            end
                        end
                    end

                    CMD_SEARCH:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STAT_NOTFOUND;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            // start at the top entry
                            mem_re     = 1'b1;
                            idx_next   = count_reg;
                            state_next = S_SEARCH;
                        end
                    end

                    CMD_CLEAR:
                    begin
                        count_next = '0;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end

                    default:
                    begin
                        // unused codes do nothing
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_READ:
            begin
                data_next  = mem_rdata;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_SEARCH:
            begin
                // read data holds the entry at idx_reg - 1
                if (mem_rdata == val_reg)
                begin
                    pos_next   = idx_reg;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (idx_reg == CW'(1))
                begin
                    status_next = STAT_NOTFOUND;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_dec2[AW-1:0];
                    idx_next  = idx_dec;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign status   = status_reg;
    assign data     = data_reg;
    assign position = pos_reg;
    assign depth    = count_reg;
    assign is_empty = (count_reg == '0);

endmodule

`default_nettype wire

### src/bounded_stack_with_search_unit.sv
// Top level: bounded LIFO stack of signed words with a top-down search.
// Steps from accepted start to done strobe: push, clear, unused codes, errors
// and a search of an empty stack end in EXEC; pop and peek add READ (one memory read).
// A search comparing k entries (1..DEPTH) walks down from the top, one read per cycle.
// One command at a time: busy drops with done, so the next beat may follow at once;
// the receiver cannot stall. Reset clears state, fill count and done, not the store.
`default_nettype none

module bounded_stack_with_search_unit
    import bss_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [CMD_W-1:0]             command,
    input  wire word_t                        value,
    output logic                              done,
    output logic [STAT_W-1:0]                 status,
    output word_t                             data,
    output logic [$clog2(DEPTH+1)-1:0]        position,
    output logic [$clog2(DEPTH+1)-1:0]        depth,
    output logic                              is_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    word_t         mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    word_t         mem_rdata;

    // Sequencer
    bss_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .value     (value),
        .done      (done),
        .status    (status),
        .data      (data),
        .position  (position),
        .depth     (depth),
        .is_empty  (is_empty),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Storage
    bss_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire
